>>> design/tds_pkg.sv
// Shared types and constants for the task dependency scheduler.
// Used by the top level and by its port checker; depends on nothing.
`default_nettype none
package tds_pkg;

	localparam int SLOT_W        = 8;
	localparam int TASK_SLOTS    = 256;
	localparam int PEND_W        = 9;
	localparam int ROUTE_W       = 5;
	localparam int MAX_FOLLOWERS = 32;
	localparam int N_WORKERS     = 4;
	localparam int PRIO_LEVELS   = 3;

	localparam logic [PEND_W-1:0] PEND_MAX       = 9'd511;
	localparam logic [PEND_W-1:0] PARENT_RELEASE = 9'd2;
	localparam logic [PEND_W:0]   QUEUE_FULL     = 10'd256;

	localparam logic [1:0] MODE_ADD      = 2'd0;
	localparam logic [1:0] MODE_SUBMIT   = 2'd1;
	localparam logic [1:0] MODE_POP      = 2'd2;
	localparam logic [1:0] MODE_COMPLETE = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_QUEUE_OVF = 2'd1;
	localparam logic [1:0] ST_CONT_OVF  = 2'd2;
	localparam logic [1:0] ST_UNUSED    = 2'd3;

	typedef logic [SLOT_W-1:0] slot_t;

endpackage
`default_nettype wire

>>> design/task_dependency_scheduler.sv
// Task dependency scheduler top level: slot records, continuation lists and ready queues.
// Depends on tds_pkg.
`default_nettype none
// Each request is one operation on a task graph of 256 slots, selected by s_tuser: add a task,
// submit it, pop a ready task for a worker, or complete a task. One request is handled at a
// time by a small sequencer around a single-port slot record memory, one ready-queue memory
// and one continuation-list memory, so the block is not ready while it works. Every slot
// record update reads and then writes on that one port. An add writes the new record and then
// updates the parent and the dependency when given, a submit reads the record, a pop scans the
// queues until one holds a task, and a complete closes the task, updates its parent if it has
// one and walks its continuations; the continuation walk and the queue scan dominate. A result
// that is not taken holds the sequencer in its last state. The result sits in an output
// register, so a new request is accepted while the previous result waits. Reset clears the
// slot records through per-slot valid bits, so no clearing pass is needed. Pushes onto a full
// ready queue and appends to a full continuation list are dropped and reported in the status
// field.
module task_dependency_scheduler
	import tds_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// task_slot[7:0], depend_slot[15:8], parent_slot[23:16], prio_level[25:24],
	// affinity_sel[28:26], worker_num[30:29], zero fill [31]
	input  wire logic [31:0] s_tdata,
	// mode[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// result_slot[7:0], slot_open[8], status[10:9], zero fill [15:11]
	output logic [15:0]      m_tdata
);

	localparam int QUEUE_COUNT = PRIO_LEVELS * (N_WORKERS + 1);
	localparam int QW          = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int RDY_AW      = QW + SLOT_W;
	localparam int RDY_DEPTH   = QUEUE_COUNT * TASK_SLOTS;
	localparam int CNT_W       = $clog2(MAX_FOLLOWERS + 1);
	localparam int CIDX_W      = (MAX_FOLLOWERS > 1) ? $clog2(MAX_FOLLOWERS) : 1;
	localparam int LST_DEPTH   = TASK_SLOTS << CIDX_W;
	localparam int LW          = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_ADD_WS   = 5'd1;
	localparam logic [4:0] S_PAR_RD   = 5'd2;
	localparam logic [4:0] S_PAR_WR   = 5'd3;
	localparam logic [4:0] S_DEP_RD   = 5'd4;
	localparam logic [4:0] S_DEP_WR   = 5'd5;
	localparam logic [4:0] S_SUB_RD   = 5'd6;
	localparam logic [4:0] S_SUB_CHK  = 5'd7;
	localparam logic [4:0] S_POP_CHK  = 5'd8;
	localparam logic [4:0] S_POP_WAIT = 5'd9;
	localparam logic [4:0] S_CMP_RD   = 5'd10;
	localparam logic [4:0] S_CMP_WT   = 5'd11;
	localparam logic [4:0] S_CPAR_RD  = 5'd12;
	localparam logic [4:0] S_CPAR_WR  = 5'd13;
	localparam logic [4:0] S_CL_RD    = 5'd14;
	localparam logic [4:0] S_CL_SLOT  = 5'd15;
	localparam logic [4:0] S_CL_PUSH  = 5'd16;
	localparam logic [4:0] S_CEND_RD  = 5'd17;
	localparam logic [4:0] S_CEND_WR  = 5'd18;
	localparam logic [4:0] S_FIN_RD   = 5'd19;
	localparam logic [4:0] S_FIN_OUT  = 5'd20;

	// Slot record memory, one field per array, shared address.
	logic                open_mem  [TASK_SLOTS];
	logic [PEND_W-1:0]   pend_mem  [TASK_SLOTS];
	logic [CNT_W-1:0]    ccnt_mem  [TASK_SLOTS];
	slot_t               par_mem   [TASK_SLOTS];
	slot_t               dep_mem   [TASK_SLOTS];
	logic [ROUTE_W-1:0]  route_mem [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] valid_q;

	logic                open_rd_q, valid_rd_q;
	logic [PEND_W-1:0]   pend_rd_q;
	logic [CNT_W-1:0]    ccnt_rd_q;
	slot_t               par_rd_q, dep_rd_q;
	logic [ROUTE_W-1:0]  route_rd_q;

	logic                rec_open;
	logic [PEND_W-1:0]   rec_pend;
	logic [CNT_W-1:0]    rec_ccnt;
	slot_t               rec_par, rec_dep;
	logic [ROUTE_W-1:0]  rec_route;

	logic                rec_re, rec_we;
	slot_t               rec_raddr, rec_waddr;
	logic                w_open;
	logic [PEND_W-1:0]   w_pend;
	logic [CNT_W-1:0]    w_ccnt;
	slot_t               w_par, w_dep;
	logic [ROUTE_W-1:0]  w_route;

	// Continuation lists and ready queue entries.
	slot_t               lst_mem [LST_DEPTH];
	slot_t               lst_rd_q;
	logic                lst_we, lst_re;
	logic [SLOT_W+CIDX_W-1:0] lst_waddr, lst_raddr;

	slot_t               rdy_mem [RDY_DEPTH];
	slot_t               rdy_rd_q;

	slot_t               qhead_q [QUEUE_COUNT];
	slot_t               qtail_q [QUEUE_COUNT];
	logic [PEND_W-1:0]   qcnt_q  [QUEUE_COUNT];

	// Sequencer and request registers.
	logic [4:0]          state_q, state_d;
	logic [1:0]          mode_q;
	slot_t               task_q, dep_q, par_q, slot_q, alloc_q, p_q;
	logic [ROUTE_W-1:0]  route_q;
	logic [1:0]          worker_q, status_q;
	logic [CNT_W-1:0]    c_q, fi_q;
	logic [LW-1:0]       i_q;
	logic                own_q;
	logic [15:0]         out_q;
	logic                out_valid_q;

	// Shared push and pop unit.
	logic                push_en, push_do, push_ovf;
	slot_t               push_slot;
	logic [ROUTE_W-1:0]  push_route;
	logic [QW-1:0]       push_q;
	logic [1:0]          push_prio;
	logic [2:0]          push_aff;
	logic                pop_do;
	logic [QW-1:0]       pop_q;
	logic                own_ok;

	logic                in_acc;
	logic [1:0]          in_prio;
	slot_t               in_alloc;
	logic                out_load;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign out_load = (state_q == S_FIN_OUT) && (!out_valid_q || m_tready);

	assign rec_open  = valid_rd_q & open_rd_q;
	assign rec_pend  = valid_rd_q ? pend_rd_q  : '0;
	assign rec_ccnt  = valid_rd_q ? ccnt_rd_q  : '0;
	assign rec_par   = valid_rd_q ? par_rd_q   : '0;
	assign rec_dep   = valid_rd_q ? dep_rd_q   : '0;
	assign rec_route = valid_rd_q ? route_rd_q : '0;

	// Priority saturates to the lowest level; slot 0 of the counter is skipped.
	always_comb begin
		if (int'(s_tdata[25:24]) >= PRIO_LEVELS) begin
			in_prio = 2'(PRIO_LEVELS - 1);
		end else begin
			in_prio = s_tdata[25:24];
		end
		in_alloc = (alloc_q == '0) ? alloc_q + 8'd1 : alloc_q;
	end

	// Queue selection for a push: affinity naming a worker picks that worker's queue.
	always_comb begin
		push_prio = push_route[1:0];
		if (int'(push_prio) >= PRIO_LEVELS) begin
			push_prio = 2'(PRIO_LEVELS - 1);
		end
		push_aff = push_route[4:2];
		if (push_aff == 3'd0 || int'(push_aff) > N_WORKERS) begin
			push_q = QW'(push_prio);
		end else begin
			push_q = QW'(int'(push_aff) * PRIO_LEVELS + int'(push_prio));
		end
		push_ovf = push_en && (push_slot != '0) && ({1'b0, qcnt_q[push_q]} >= QUEUE_FULL);
		push_do  = push_en && (push_slot != '0) && !push_ovf;
	end

	// Pop scan: own queue, then the global queue, at each priority.
	always_comb begin
		own_ok = own_q && (int'(worker_q) < N_WORKERS);
		if (own_ok) begin
			pop_q = QW'((int'(worker_q) + 1) * PRIO_LEVELS + int'(i_q));
		end else begin
			pop_q = QW'(i_q);
		end
		pop_do = (state_q == S_POP_CHK) && (own_ok || !own_q) && (qcnt_q[pop_q] != '0);
	end

	always_comb begin
		state_d    = state_q;
		rec_re     = 1'b0;
		rec_raddr  = task_q;
		rec_we     = 1'b0;
		rec_waddr  = task_q;
		w_open     = rec_open;
		w_pend     = rec_pend;
		w_ccnt     = rec_ccnt;
		w_par      = rec_par;
		w_dep      = rec_dep;
		w_route    = rec_route;
		push_en    = 1'b0;
		push_slot  = task_q;
		push_route = rec_route;
		lst_we     = 1'b0;
		lst_waddr  = {dep_q, rec_ccnt[CIDX_W-1:0]};
		lst_re     = 1'b0;
		lst_raddr  = {task_q, fi_q[CIDX_W-1:0]};
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (s_tuser)
						MODE_ADD:    state_d = S_ADD_WS;
						MODE_SUBMIT: state_d = S_SUB_RD;
						MODE_POP:    state_d = S_POP_CHK;
						default:     state_d = S_CMP_RD;
					endcase
				end
			end
			S_ADD_WS: begin
				rec_we    = 1'b1;
				rec_waddr = slot_q;
				w_open    = 1'b1;
				w_pend    = 9'd1;
				w_ccnt    = '0;
				w_par     = par_q;
				w_dep     = dep_q;
				w_route   = route_q;
				if (par_q != '0) begin
					state_d = S_PAR_RD;
				end else if (dep_q != '0) begin
					state_d = S_DEP_RD;
				end else begin
					state_d = S_FIN_RD;
				end
			end
			S_PAR_RD: begin
				rec_re    = 1'b1;
				rec_raddr = par_q;
				state_d   = S_PAR_WR;
			end
			S_PAR_WR: begin
				rec_we    = 1'b1;
				rec_waddr = par_q;
				if (rec_pend != PEND_MAX) begin
					w_pend = rec_pend + 9'd1;
				end
				state_d = (dep_q != '0) ? S_DEP_RD : S_FIN_RD;
			end
			S_DEP_RD: begin
				rec_re    = 1'b1;
				rec_raddr = dep_q;
				state_d   = S_DEP_WR;
			end
			S_DEP_WR: begin
				if (int'(rec_ccnt) < MAX_FOLLOWERS) begin
					lst_we    = 1'b1;
					rec_we    = 1'b1;
					rec_waddr = dep_q;
					w_ccnt    = rec_ccnt + CNT_W'(1);
				end
				state_d = S_FIN_RD;
			end
			S_SUB_RD: begin
				rec_re  = 1'b1;
				state_d = S_SUB_CHK;
			end
			S_SUB_CHK: begin
				push_en = (rec_dep == '0) && (rec_pend == 9'd1);
				state_d = S_FIN_RD;
			end
			S_POP_CHK: begin
				if (pop_do) begin
					state_d = S_POP_WAIT;
				end else if (!own_q && int'(i_q) == PRIO_LEVELS - 1) begin
					state_d = S_FIN_RD;
				end
			end
			S_POP_WAIT: begin
				state_d = S_FIN_RD;
			end
			S_CMP_RD: begin
				rec_re  = 1'b1;
				state_d = S_CMP_WT;
			end
			S_CMP_WT: begin
				rec_we  = 1'b1;
				w_open  = 1'b0;
				state_d = (rec_par != '0) ? S_CPAR_RD : S_CL_RD;
			end
			S_CPAR_RD: begin
				rec_re    = 1'b1;
				rec_raddr = p_q;
				state_d   = S_CPAR_WR;
			end
			S_CPAR_WR: begin
				rec_we    = 1'b1;
				rec_waddr = p_q;
				if (rec_pend != '0) begin
					w_pend = rec_pend - 9'd1;
				end
				push_en   = (rec_pend == PARENT_RELEASE);
				push_slot = p_q;
				state_d   = S_CL_RD;
			end
			S_CL_RD: begin
				if (fi_q < c_q) begin
					lst_re  = 1'b1;
					state_d = S_CL_SLOT;
				end else begin
					state_d = S_CEND_RD;
				end
			end
			S_CL_SLOT: begin
				rec_re    = 1'b1;
				rec_raddr = lst_rd_q;
				state_d   = S_CL_PUSH;
			end
			S_CL_PUSH: begin
				push_en   = 1'b1;
				push_slot = lst_rd_q;
				state_d   = S_CL_RD;
			end
			S_CEND_RD: begin
				rec_re  = 1'b1;
				state_d = S_CEND_WR;
			end
			S_CEND_WR: begin
				rec_we  = 1'b1;
				w_pend  = '0;
				state_d = S_FIN_RD;
			end
			S_FIN_RD: begin
				rec_re  = 1'b1;
				state_d = S_FIN_OUT;
			end
			S_FIN_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Slot record memory.
	always_ff @(posedge clk) begin
		if (rec_we) begin
			open_mem[rec_waddr]  <= w_open;
			pend_mem[rec_waddr]  <= w_pend;
			ccnt_mem[rec_waddr]  <= w_ccnt;
			par_mem[rec_waddr]   <= w_par;
			dep_mem[rec_waddr]   <= w_dep;
			route_mem[rec_waddr] <= w_route;
		end
		if (rec_re) begin
			open_rd_q  <= open_mem[rec_raddr];
			pend_rd_q  <= pend_mem[rec_raddr];
			ccnt_rd_q  <= ccnt_mem[rec_raddr];
			par_rd_q   <= par_mem[rec_raddr];
			dep_rd_q   <= dep_mem[rec_raddr];
			route_rd_q <= route_mem[rec_raddr];
		end
	end

	// A slot never written reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (rec_we) begin
				valid_q[rec_waddr] <= 1'b1;
			end
			if (rec_re) begin
				valid_rd_q <= valid_q[rec_raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lst_we) begin
			lst_mem[lst_waddr] <= slot_q;
		end
		if (lst_re) begin
			lst_rd_q <= lst_mem[lst_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (push_do) begin
			rdy_mem[RDY_AW'({push_q, qtail_q[push_q]})] <= push_slot;
		end
		if (pop_do) begin
			rdy_rd_q <= rdy_mem[RDY_AW'({pop_q, qhead_q[pop_q]})];
		end
	end

	// Ready queue pointers; a push and a pop never fall in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < QUEUE_COUNT; q++) begin
				qhead_q[q] <= '0;
				qtail_q[q] <= '0;
				qcnt_q[q]  <= '0;
			end
		end else if (push_do) begin
			qtail_q[push_q] <= qtail_q[push_q] + 8'd1;
			qcnt_q[push_q]  <= qcnt_q[push_q] + 9'd1;
		end else if (pop_do) begin
			qhead_q[pop_q] <= qhead_q[pop_q] + 8'd1;
			qcnt_q[pop_q]  <= qcnt_q[pop_q] - 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alloc_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			i_q         <= '0;
			own_q       <= 1'b1;
			fi_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				status_q <= ST_OK;
				i_q      <= '0;
				own_q    <= 1'b1;
				fi_q     <= '0;
				if (s_tuser == MODE_ADD) begin
					alloc_q <= in_alloc + 8'd1;
				end
			end
			if (push_ovf) begin
				status_q <= ST_QUEUE_OVF;
			end
			if (state_q == S_DEP_WR && int'(rec_ccnt) >= MAX_FOLLOWERS) begin
				status_q <= ST_CONT_OVF;
			end
			if (state_q == S_POP_CHK && !pop_do) begin
				if (own_q) begin
					own_q <= 1'b0;
				end else if (int'(i_q) != PRIO_LEVELS - 1) begin
					i_q   <= i_q + LW'(1);
					own_q <= 1'b1;
				end
			end
			if (state_q == S_CL_PUSH) begin
				fi_q <= fi_q + CNT_W'(1);
			end
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q   <= s_tuser;
			task_q   <= s_tdata[7:0];
			dep_q    <= s_tdata[15:8];
			par_q    <= s_tdata[23:16];
			route_q  <= {s_tdata[28:26], in_prio};
			worker_q <= s_tdata[30:29];
			slot_q   <= (s_tuser == MODE_ADD) ? in_alloc : 8'd0;
		end
		if (state_q == S_POP_WAIT) begin
			slot_q <= rdy_rd_q;
		end
		if (state_q == S_CMP_WT) begin
			p_q <= rec_par;
			c_q <= (int'(rec_ccnt) > MAX_FOLLOWERS) ? CNT_W'(MAX_FOLLOWERS) : rec_ccnt;
		end
		if (out_load) begin
			out_q <= {5'd0, status_q, rec_open, (mode_q == MODE_ADD ||
				mode_q == MODE_POP) ? slot_q : 8'd0};
		end
	end

endmodule
`default_nettype wire

>>> design/tds_checker.sv
// Port checker for the task dependency scheduler, bound to the top level.
// Depends on tds_pkg and task_dependency_scheduler.
`default_nettype none
module tds_checker
	import tds_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only one request is in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// Status never carries the unused code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:9] != ST_UNUSED)
		else $error("illegal status code");

	// The fill bits above the status are always zero.
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:11] == 5'd0)
		else $error("nonzero fill bits in result");

endmodule

bind task_dependency_scheduler tds_checker u_tds_checker (.*);
`default_nettype wire

>>> sim/task_dependency_scheduler_test.sv
// Self-checking testbench for the task dependency scheduler: directed and random task-graph
// traffic, checked against a behavioral scheduler model. Depends on tds_pkg and the top level.
`timescale 1ns / 1ps
`default_nettype none
module task_dependency_scheduler_test;
	import tds_pkg::*;

	localparam int QUEUES      = 15;
	localparam int FOLLOW_MAX  = 32;
	localparam int WORKERS     = 4;
	localparam int LEVELS      = 3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_AT     = 5000;
	localparam int HOLD_LEN    = 400;
	localparam int QUIET_FROM  = 1000;
	localparam int QUIET_TO    = 3000;

	typedef struct packed {
		logic [1:0] mode;
		slot_t      task_slot;
		slot_t      depend_slot;
		slot_t      parent_slot;
		logic [1:0] prio_level;
		logic [2:0] affinity_sel;
		logic [1:0] worker_num;
	} sched_req_t;

	typedef struct packed {
		slot_t      result_slot;
		logic       slot_open;
		logic [1:0] status;
	} sched_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	// Requests waiting to be driven, and responses the model has predicted.
	sched_req_t req_q[$];
	sched_rsp_t rsp_want_q[$];

	int  cycle_cnt = 0;
	int  err_cnt = 0;
	bit  req_taken = 1'b0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	// Scheduler model state.
	bit          m_open[TASK_SLOTS];
	logic [8:0]  m_pend[TASK_SLOTS];
	logic [5:0]  m_cont_cnt[TASK_SLOTS];
	slot_t       m_cont[TASK_SLOTS][FOLLOW_MAX];
	slot_t       m_parent[TASK_SLOTS];
	slot_t       m_depend[TASK_SLOTS];
	logic [4:0]  m_route[TASK_SLOTS];
	slot_t       m_alloc;
	slot_t       m_ready[QUEUES][$];

	// Allocation counter as the stimulus generator sees it, used to aim at live slots.
	slot_t gen_alloc = '0;
	slot_t gen_last = '0;

	task_dependency_scheduler u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Pushes a slot onto the ready queue its route selects; returns 1 when the queue is full.
	function automatic bit ready_push(slot_t slot);
		logic [1:0] p;
		logic [2:0] a;
		int q;
		if (slot == 0) return 1'b0;
		p = m_route[slot][1:0];
		if (p >= LEVELS) p = 2'(LEVELS - 1);
		a = m_route[slot][4:2];
		if (a == 0 || a > WORKERS) q = p;
		else q = LEVELS + (a - 1) * LEVELS + p;
		if (m_ready[q].size() >= TASK_SLOTS) return 1'b1;
		m_ready[q].push_back(slot);
		return 1'b0;
	endfunction

	function automatic slot_t ready_pop(int q);
		if (m_ready[q].size() == 0) return '0;
		return m_ready[q].pop_front();
	endfunction

	// Applies one accepted request to the model and returns the response it should produce.
	function automatic sched_rsp_t schedule_step(sched_req_t r);
		sched_rsp_t rsp;
		logic [1:0] prio;
		slot_t s, p;
		logic [8:0] old;
		rsp = '0;
		prio = (r.prio_level >= LEVELS) ? 2'(LEVELS - 1) : r.prio_level;
		case (r.mode)
			MODE_ADD: begin
				s = m_alloc;
				m_alloc = m_alloc + 8'd1;
				if (s == 0) begin
					s = m_alloc;
					m_alloc = m_alloc + 8'd1;
				end
				m_open[s] = 1'b1;
				m_pend[s] = 9'd1;
				m_cont_cnt[s] = '0;
				m_parent[s] = r.parent_slot;
				m_depend[s] = r.depend_slot;
				m_route[s] = {r.affinity_sel, prio};
				if (r.parent_slot != 0 && m_pend[r.parent_slot] < PEND_MAX)
					m_pend[r.parent_slot]++;
				if (r.depend_slot != 0) begin
					if (m_cont_cnt[r.depend_slot] >= FOLLOW_MAX) begin
						rsp.status = ST_CONT_OVF;
					end else begin
						m_cont[r.depend_slot][m_cont_cnt[r.depend_slot]] = s;
						m_cont_cnt[r.depend_slot]++;
					end
				end
				rsp.result_slot = s;
			end
			MODE_SUBMIT: begin
				if (m_depend[r.task_slot] == 0 && m_pend[r.task_slot] == 9'd1)
					if (ready_push(r.task_slot)) rsp.status = ST_QUEUE_OVF;
			end
			MODE_POP: begin
				// Per level, the worker's own queue goes before the global one.
				for (int i = 0; i < LEVELS && rsp.result_slot == 0; i++) begin
					if (r.worker_num < WORKERS)
						rsp.result_slot = ready_pop(LEVELS + r.worker_num * LEVELS + i);
					if (rsp.result_slot == 0) rsp.result_slot = ready_pop(i);
				end
			end
			default: begin
				p = m_parent[r.task_slot];
				m_open[r.task_slot] = 1'b0;
				if (p != 0) begin
					old = m_pend[p];
					if (old > 0) m_pend[p] = old - 9'd1;
					if (old == PARENT_RELEASE && ready_push(p)) rsp.status = ST_QUEUE_OVF;
				end
				for (int i = 0; i < m_cont_cnt[r.task_slot] && i < FOLLOW_MAX; i++)
					if (ready_push(m_cont[r.task_slot][i])) rsp.status = ST_QUEUE_OVF;
				m_pend[r.task_slot] = '0;
			end
		endcase
		rsp.slot_open = m_open[r.task_slot];
		return rsp;
	endfunction

	task automatic put_req(logic [1:0] mode, slot_t t, slot_t d, slot_t p,
			logic [1:0] pr, logic [2:0] af, logic [1:0] w);
		req_q.push_back('{mode, t, d, p, pr, af, w});
		if (mode == MODE_ADD) begin
			gen_last = gen_alloc;
			gen_alloc = gen_alloc + 8'd1;
			if (gen_last == 0) begin
				gen_last = gen_alloc;
				gen_alloc = gen_alloc + 8'd1;
			end
		end
	endtask

	// Picks a slot up to 12 below the last one handed out, wrapping around below slot 0.
	function automatic slot_t recent_slot();
		slot_t s;
		s = gen_last - slot_t'($urandom_range(0, 12));
		return s;
	endfunction

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Request driver: a new request is offered once the current one was taken.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (req_q.size() > 0 && (cycle_cnt inside {[QUIET_FROM:QUIET_TO]} ||
					$urandom_range(0, 99) >= 25)) begin
				sched_req_t r;
				r = req_q.pop_front();
				s_tdata <= {1'b0, r.worker_num, r.affinity_sel, r.prio_level,
					r.parent_slot, r.depend_slot, r.task_slot};
				s_tuser <= r.mode;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Response ready: random idling, plus one long hold-off that backs the block up.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && cycle_cnt >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			m_tready <= 1'b0;
		end else begin
			m_tready <= (cycle_cnt inside {[QUIET_FROM:QUIET_TO]}) ||
				($urandom_range(0, 99) >= 25);
		end
	end

	// Monitor: predicts on each accepted request and checks each accepted response.
	always @(posedge clk) begin
		req_taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			rsp_want_q.push_back(schedule_step(sched_req_t'({s_tuser, s_tdata[7:0],
				s_tdata[15:8], s_tdata[23:16], s_tdata[25:24], s_tdata[28:26],
				s_tdata[30:29]})));
		end
		if (m_tvalid && m_tready) begin
			if (rsp_want_q.size() == 0) begin
				$error("unexpected response %h", m_tdata);
				err_cnt++;
			end else begin
				sched_rsp_t w;
				w = rsp_want_q.pop_front();
				if (m_tdata[7:0] !== w.result_slot) begin
					$error("result_slot: expected %0d, got %0d", w.result_slot, m_tdata[7:0]);
					err_cnt++;
				end
				if (m_tdata[8] !== w.slot_open) begin
					$error("slot_open: expected %0d, got %0d", w.slot_open, m_tdata[8]);
					err_cnt++;
				end
				if (m_tdata[10:9] !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, m_tdata[10:9]);
					err_cnt++;
				end
				if (m_tdata[15:11] !== 5'd0) begin
					$error("fill: expected 0, got %0d", m_tdata[15:11]);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		slot_t hub, t, d, p;
		int pick;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			m_open[i] = 0;
			m_pend[i] = '0;
			m_cont_cnt[i] = '0;
			m_parent[i] = '0;
			m_depend[i] = '0;
			m_route[i] = '0;
		end
		m_alloc = '0;

		// Directed part: empty pops, operations on slot 0 and on never-added slots, range
		// extremes of priority, affinity and worker, and a small chain with a parent.
		put_req(MODE_POP, 8'd0, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		put_req(MODE_POP, 8'd255, 8'd0, 8'd0, 2'd0, 3'd0, 2'd3);
		put_req(MODE_SUBMIT, 8'd0, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		put_req(MODE_COMPLETE, 8'd200, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		put_req(MODE_ADD, 8'd0, 8'd0, 8'd0, 2'd3, 3'd7, 2'd0);
		put_req(MODE_ADD, 8'd0, 8'd0, 8'd1, 2'd0, 3'd1, 2'd0);
		put_req(MODE_ADD, 8'd0, 8'd1, 8'd0, 2'd2, 3'd4, 2'd0);
		put_req(MODE_ADD, 8'd0, 8'd255, 8'd255, 2'd1, 3'd5, 2'd0);
		put_req(MODE_ADD, 8'd0, 8'd0, 8'd0, 2'd0, 3'd6, 2'd0);
		put_req(MODE_SUBMIT, 8'd1, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		put_req(MODE_SUBMIT, 8'd2, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		put_req(MODE_SUBMIT, 8'd5, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		put_req(MODE_SUBMIT, 8'd3, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		put_req(MODE_POP, 8'd2, 8'd0, 8'd0, 2'd0, 3'd0, 2'd3);
		put_req(MODE_POP, 8'd2, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		put_req(MODE_COMPLETE, 8'd2, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		put_req(MODE_COMPLETE, 8'd1, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		put_req(MODE_COMPLETE, 8'd1, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		put_req(MODE_POP, 8'd3, 8'd0, 8'd0, 2'd0, 3'd0, 2'd3);
		put_req(MODE_POP, 8'd3, 8'd0, 8'd0, 2'd0, 3'd0, 2'd1);
		put_req(MODE_POP, 8'd0, 8'd0, 8'd0, 2'd0, 3'd0, 2'd2);

		// A full continuation list: 33 followers of one task, then its completion.
		put_req(MODE_ADD, 8'd0, 8'd0, 8'd0, 2'd1, 3'd2, 2'd0);
		hub = gen_last;
		for (int i = 0; i < FOLLOW_MAX + 1; i++)
			put_req(MODE_ADD, 8'd0, hub, 8'd0, 2'($urandom_range(0, 3)), 3'd2, 2'd0);
		put_req(MODE_COMPLETE, hub, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		for (int i = 0; i < FOLLOW_MAX + 1; i++)
			put_req(MODE_POP, 8'd0, 8'd0, 8'd0, 2'd0, 3'd0, 2'd1);

		// A full ready queue: one task submitted until the queue overflows, then drained.
		put_req(MODE_ADD, 8'd0, 8'd0, 8'd0, 2'd0, 3'd1, 2'd0);
		hub = gen_last;
		for (int i = 0; i < TASK_SLOTS + 2; i++)
			put_req(MODE_SUBMIT, hub, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);
		for (int i = 0; i < TASK_SLOTS + 1; i++)
			put_req(MODE_POP, 8'd0, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);

		// Pending count saturation: one parent gets more than 511 children.
		put_req(MODE_ADD, 8'd0, 8'd0, 8'd0, 2'd2, 3'd0, 2'd0);
		hub = gen_last;
		for (int i = 0; i < 515; i++)
			put_req(MODE_ADD, 8'd0, 8'd0, hub, 2'($urandom_range(0, 3)),
				3'($urandom_range(0, 7)), 2'd0);
		put_req(MODE_SUBMIT, hub, 8'd0, 8'd0, 2'd0, 3'd0, 2'd0);

		// Random part: mostly graph traffic on recently added slots, some raw noise.
		for (int i = 0; i < 580; i++) begin
			pick = $urandom_range(0, 99);
			t = recent_slot();
			d = ($urandom_range(0, 2) == 0) ? recent_slot() : 8'd0;
			p = ($urandom_range(0, 2) == 0) ? recent_slot() : 8'd0;
			if (pick < 10)
				put_req(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					2'($urandom), 3'($urandom), 2'($urandom));
			else if (pick < 40)
				put_req(MODE_ADD, 8'($urandom), d, p, 2'($urandom_range(0, 3)),
					3'($urandom_range(0, 7)), 2'($urandom));
			else if (pick < 60)
				put_req(MODE_SUBMIT, t, 8'($urandom), 8'($urandom), 2'($urandom),
					3'($urandom), 2'($urandom));
			else if (pick < 80)
				put_req(MODE_POP, t, 8'($urandom), 8'($urandom), 2'($urandom),
					3'($urandom), 2'($urandom));
			else
				put_req(MODE_COMPLETE, t, 8'($urandom), 8'($urandom), 2'($urandom),
					3'($urandom), 2'($urandom));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (req_q.size() == 0 && !s_tvalid && rsp_want_q.size() == 0);
		repeat (200) @(posedge clk);
		if (err_cnt == 0 && rsp_want_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire
